[design/utf8_stream_validator_defines.svh]
// ----------------------------------------------------------------------------
// UTF-8 stream validator assertion macros
// Concurrent assertion wrappers; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_VALIDATOR_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define USV_ASSERT(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define USV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define USV_ASSERT(lbl, clk, rst, expr, msg)
`define USV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[design/usv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream validator package
// Shared constants and the sequence state type.
// ----------------------------------------------------------------------------
package usv_pkg;

   localparam int unsigned CpWidth = 21;

   localparam logic [7:0] AsciiLimit = 8'h80;
   localparam logic [7:0] Lead2Mask  = 8'hE0;
   localparam logic [7:0] Lead2Code  = 8'hC0;
   localparam logic [7:0] Lead3Mask  = 8'hF0;
   localparam logic [7:0] Lead3Code  = 8'hE0;
   localparam logic [7:0] Lead4Mask  = 8'hF8;
   localparam logic [7:0] Lead4Code  = 8'hF0;
   localparam logic [7:0] ContMask   = 8'hC0;
   localparam logic [7:0] ContCode   = 8'h80;

   localparam logic [CpWidth-1:0] MinLen1   = 21'h00080;
   localparam logic [CpWidth-1:0] MinLen2   = 21'h00800;
   localparam logic [CpWidth-1:0] MinLen3   = 21'h10000;
   localparam logic [CpWidth-1:0] MaxCp     = 21'h10FFFF;
   localparam logic [CpWidth-1:0] SurrLow   = 21'h0D800;
   localparam logic [CpWidth-1:0] SurrHigh  = 21'h0DFFF;

   typedef struct packed {
      logic [1:0]         pend;
      logic [CpWidth-1:0] cp;
      logic [1:0]         len;
      logic               err;
   } usv_state_type;

endpackage

[design/usv_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream validator channels
// Byte request channel and verdict response channel, valid/ready.
// ----------------------------------------------------------------------------
interface usv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface usv_rsp_if;
   logic valid;
   logic ready;
   logic valid_so_far;
   logic verdict_ready;

   modport source (output valid, output valid_so_far, output verdict_ready, input ready);
   modport sink   (input valid, input valid_so_far, input verdict_ready, output ready);
endinterface

[design/utf8_stream_validator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream validator
// Checks a byte stream for well-formed UTF-8, one verdict per transaction.
// Path: a request byte is registered in the input stage, then in the output stage, before its response.
// Throughput: one byte per cycle unless the response channel stalls; set by the sequence state update.
// Reset: synchronous, clears pipeline valids and sequence state; no clearing pass.
// ----------------------------------------------------------------------------
`include "utf8_stream_validator_defines.svh"

module utf8_stream_validator
   import usv_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   usv_req_if.sink   req_chan,
   usv_rsp_if.source rsp_chan
);

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff;
   logic          in_eom_ff;
   usv_state_type state_ff, state_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_ok_ff;
   logic          out_eom_ff;

   logic          advance;
   logic          fire;
   logic          take;
   logic          dec_ok;

   assign advance = !out_valid_ff || rsp_chan.ready;
   assign fire    = in_valid_ff && advance;
   assign take    = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;

   usv_decode u_decode (
      .cur_state      (state_ff),
      .data_byte      (in_byte_ff),
      .end_of_message (in_eom_ff),
      .nxt_state      (state_in),
      .valid_so_far   (dec_ok)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_chan.data_byte;
         in_eom_ff  <= req_chan.end_of_message;
      end
      if (fire) begin
         out_ok_ff  <= dec_ok;
         out_eom_ff <= in_eom_ff;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.valid_so_far  = out_ok_ff;
   assign rsp_chan.verdict_ready = out_eom_ff;

   `USV_ASSERT(a_pend_le_len, clock, reset, state_ff.pend <= state_ff.len, "pending exceeds length")
   `USV_ASSERT_NEXT(a_clear_after_eom, clock, reset, fire && in_eom_ff, state_ff == usv_state_type'('0), "state not cleared after message end")
   `USV_ASSERT_NEXT(a_err_sticky, clock, reset, state_ff.err && !(fire && in_eom_ff), state_ff.err, "error mark dropped mid-message")

endmodule

[design/usv_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream validator byte decoder
// Next sequence state and running verdict for one byte.
// ----------------------------------------------------------------------------
module usv_decode
   import usv_pkg::*;
(
   input  usv_state_type cur_state,
   input  logic [7:0]    data_byte,
   input  logic          end_of_message,
   output usv_state_type nxt_state,
   output logic          valid_so_far
);

   usv_state_type      st;
   logic [CpWidth-1:0] cp_shift;
   logic [CpWidth-1:0] lowest;
   logic [1:0]         pend_dec;
   logic               cp_bad;

   assign cp_shift = {cur_state.cp[CpWidth-7:0], data_byte[5:0]};
   assign pend_dec = cur_state.pend - 2'd1;

   always_comb begin
      unique case (cur_state.len)
         2'd1:    lowest = MinLen1;
         2'd2:    lowest = MinLen2;
         default: lowest = MinLen3;
      endcase
   end

   assign cp_bad = (cp_shift < lowest) || (cp_shift > MaxCp) ||
                   ((cp_shift >= SurrLow) && (cp_shift <= SurrHigh));

   always_comb begin
      st = cur_state;
      if (!cur_state.err) begin
         if (cur_state.pend == 2'd0) begin
            priority if (data_byte == 8'h00) begin
               st.err = 1'b1;
            end else if (data_byte < AsciiLimit) begin
               st = cur_state;
            end else if ((data_byte & Lead2Mask) == Lead2Code) begin
               st.pend = 2'd1;
               st.len  = 2'd1;
               st.cp   = {{(CpWidth-5){1'b0}}, data_byte[4:0]};
            end else if ((data_byte & Lead3Mask) == Lead3Code) begin
               st.pend = 2'd2;
               st.len  = 2'd2;
               st.cp   = {{(CpWidth-4){1'b0}}, data_byte[3:0]};
            end else if ((data_byte & Lead4Mask) == Lead4Code) begin
               st.pend = 2'd3;
               st.len  = 2'd3;
               st.cp   = {{(CpWidth-3){1'b0}}, data_byte[2:0]};
            end else begin
               st.err = 1'b1;
            end
         end else if ((data_byte & ContMask) != ContCode) begin
            st.err = 1'b1;
         end else begin
            st.pend = pend_dec;
            st.cp   = cp_shift;
            if (pend_dec == 2'd0) begin
               st.err = cp_bad;
               st.cp  = '0;
               st.len = 2'd0;
            end
         end
      end
      // sequence cut off by end of message
      if (end_of_message && (st.pend != 2'd0)) begin
         st.err = 1'b1;
      end
   end

   assign valid_so_far = !st.err;
   assign nxt_state    = end_of_message ? usv_state_type'('0) : st;

endmodule

[verif/tb_utf8_stream_validator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream validator testbench
// Streams directed and random messages through the byte channel, predicts
// each per-byte verdict with its own UTF-8 decoder and compares every
// response transaction in order, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_utf8_stream_validator;
   import usv_pkg::*;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } msg_byte_type;

   typedef struct packed {
      logic valid_so_far;
      logic verdict_ready;
   } verdict_type;

   localparam int unsigned RandomBytes = 1550;
   localparam int unsigned StallLimit  = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   usv_req_if req_chan ();
   usv_rsp_if rsp_chan ();

   utf8_stream_validator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   msg_byte_type byte_queue[$];
   verdict_type  expected_verdicts[$];
   int unsigned mismatches = 0;
   int unsigned req_gap = 0;
   int unsigned rsp_gap = 0;
   int unsigned calm_left = 0;
   int unsigned stall_cycles = 0;

   // decoder state mirrored from the byte stream
   logic [1:0]         pend_cnt = '0;
   logic [CpWidth-1:0] cp_acc = '0;
   logic [1:0]         seq_len = '0;
   logic               msg_err = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit pacing_allowed();
      return (byte_queue.size() > 150) && (calm_left == 0);
   endfunction

   task automatic track_utf8_byte(input logic [7:0] b, input logic last, output logic ok);
      logic [CpWidth-1:0] lowest;
      if (!msg_err) begin
         if (pend_cnt == 2'd0) begin
            if (b == 8'h00) begin
               msg_err = 1'b1;
            end else if (b < AsciiLimit) begin
               msg_err = 1'b0;
            end else if ((b & Lead2Mask) == Lead2Code) begin
               pend_cnt = 2'd1;
               seq_len  = 2'd1;
               cp_acc   = {16'd0, b[4:0]};
            end else if ((b & Lead3Mask) == Lead3Code) begin
               pend_cnt = 2'd2;
               seq_len  = 2'd2;
               cp_acc   = {17'd0, b[3:0]};
            end else if ((b & Lead4Mask) == Lead4Code) begin
               pend_cnt = 2'd3;
               seq_len  = 2'd3;
               cp_acc   = {18'd0, b[2:0]};
            end else begin
               msg_err = 1'b1;
            end
         end else if ((b & ContMask) != ContCode) begin
            msg_err = 1'b1;
         end else begin
            cp_acc   = {cp_acc[CpWidth-7:0], b[5:0]};
            pend_cnt = pend_cnt - 2'd1;
            if (pend_cnt == 2'd0) begin
               case (seq_len)
                  2'd1:    lowest = MinLen1;
                  2'd2:    lowest = MinLen2;
                  default: lowest = MinLen3;
               endcase
               if (cp_acc < lowest || cp_acc > MaxCp || (cp_acc >= SurrLow && cp_acc <= SurrHigh))
                  msg_err = 1'b1;
               cp_acc  = '0;
               seq_len = '0;
            end
         end
      end
      if (last && pend_cnt != 2'd0)
         msg_err = 1'b1;
      ok = !msg_err;
      if (last) begin
         pend_cnt = '0;
         cp_acc   = '0;
         seq_len  = '0;
         msg_err  = 1'b0;
      end
   endtask

   // --- stimulus construction ---

   function automatic logic [20:0] pick_cp(input int unsigned lo, input int unsigned hi);
      int unsigned sel;
      sel = $urandom_range(0, 7);
      if (sel == 0)
         return lo[20:0];
      if (sel == 1)
         return hi[20:0];
      return 21'($urandom_range(lo, hi));
   endfunction

   task automatic put_char(ref logic [7:0] m[$], input logic [20:0] cp, input int unsigned n);
      case (n)
         1: m.push_back(cp[7:0]);
         2: begin
            m.push_back(Lead2Code | {3'b000, cp[10:6]});
            m.push_back(ContCode | {2'b00, cp[5:0]});
         end
         3: begin
            m.push_back(Lead3Code | {4'b0000, cp[15:12]});
            m.push_back(ContCode | {2'b00, cp[11:6]});
            m.push_back(ContCode | {2'b00, cp[5:0]});
         end
         default: begin
            m.push_back(Lead4Code | {5'b00000, cp[20:18]});
            m.push_back(ContCode | {2'b00, cp[17:12]});
            m.push_back(ContCode | {2'b00, cp[11:6]});
            m.push_back(ContCode | {2'b00, cp[5:0]});
         end
      endcase
   endtask

   task automatic put_good_char(ref logic [7:0] m[$]);
      int unsigned n;
      logic [20:0] cp;
      n = $urandom_range(1, 4);
      case (n)
         1: cp = pick_cp(1, 'h7F);
         2: cp = pick_cp('h80, 'h7FF);
         3: begin
            cp = pick_cp('h800, 'hFFFF);
            if (cp >= SurrLow && cp <= SurrHigh)
               cp = cp ^ 21'h04000;
         end
         default: cp = pick_cp('h10000, 'h10FFFF);
      endcase
      put_char(m, cp, n);
   endtask

   task automatic put_bad_char(ref logic [7:0] m[$]);
      int unsigned n;
      case ($urandom_range(0, 6))
         0: begin
            n = $urandom_range(2, 4);
            put_char(m, pick_cp(0, (n == 2) ? 'h7F : (n == 3) ? 'h7FF : 'hFFFF), n);
         end
         1: put_char(m, pick_cp(SurrLow, SurrHigh), 3);
         2: put_char(m, pick_cp('h110000, 'h1FFFFF), 4);
         3: m.push_back(8'h00);
         4: m.push_back(8'($urandom_range('h80, 'hBF)));
         5: m.push_back(8'($urandom_range('hF8, 'hFF)));
         default: begin
            m.push_back(8'($urandom_range('hC0, 'hF7)));
            m.push_back(8'($urandom_range('h01, 'h7F)));
         end
      endcase
   endtask

   task automatic queue_message(ref logic [7:0] m[$]);
      foreach (m[i])
         byte_queue.push_back('{m[i], (i == m.size() - 1)});
   endtask

   task automatic build_random_message(ref logic [7:0] m[$]);
      int unsigned nchar, fault, bad_at, mark, extra;
      m = {};
      nchar  = $urandom_range(1, 10);
      fault  = $urandom_range(0, 9);
      bad_at = $urandom_range(0, nchar);
      for (int k = 0; k <= nchar; k++) begin
         if (fault >= 6 && fault <= 7 && k == bad_at)
            put_bad_char(m);
         if (k < nchar)
            put_good_char(m);
      end
      if (fault == 8) begin
         mark = m.size();
         put_good_char(m);
         extra = m.size() - mark;
         if (extra > 1)
            repeat ($urandom_range(1, extra - 1)) void'(m.pop_back());
      end else if (fault == 9) begin
         m[$urandom_range(0, m.size() - 1)] = 8'($urandom_range(0, 255));
      end
   endtask

   // --- request driver ---
   always @(posedge clock) begin
      msg_byte_type nb;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_gap <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_gap != 0) begin
            req_chan.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (byte_queue.size() != 0) begin
            nb = byte_queue.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.data_byte <= nb.data_byte;
            req_chan.end_of_message <= nb.end_of_message;
            if (pacing_allowed() && $urandom_range(0, 9) == 0)
               req_gap <= $urandom_range(1, 13);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // --- response back-pressure ---
   always @(posedge clock) begin
      if (calm_left != 0)
         calm_left <= calm_left - 1;
      else if ($urandom_range(0, 199) == 0)
         calm_left <= $urandom_range(30, 120);
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap <= 0;
      end else if (rsp_gap != 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else if (pacing_allowed() && $urandom_range(0, 11) == 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap <= $urandom_range(0, 12);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // --- monitor and checker ---
   always @(posedge clock) begin
      verdict_type want;
      logic        ok_bit;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            track_utf8_byte(req_chan.data_byte, req_chan.end_of_message, ok_bit);
            expected_verdicts.push_back('{ok_bit, req_chan.end_of_message});
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_verdicts.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("unexpected response transaction: valid_so_far=%0b verdict_ready=%0b",
                           rsp_chan.valid_so_far, rsp_chan.verdict_ready);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_chan.valid_so_far !== want.valid_so_far ||
                   rsp_chan.verdict_ready !== want.verdict_ready) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10)
                     $display("mismatch: valid_so_far exp %0b got %0b, verdict_ready exp %0b got %0b",
                              want.valid_so_far, rsp_chan.valid_so_far,
                              want.verdict_ready, rsp_chan.verdict_ready);
               end
            end
         end
      end
   end

   // --- watchdog ---
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [7:0]  msg[$];
      int unsigned directed_bytes;
      req_chan.valid = 1'b0;
      req_chan.data_byte = 8'h00;
      req_chan.end_of_message = 1'b0;
      rsp_chan.ready = 1'b0;

      // well-formed: field extremes, bottom of the two-byte range and top of the other lengths
      msg = '{8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
      queue_message(msg);
      msg = '{8'h00};
      queue_message(msg);
      // stray continuation, then a byte ignored after the error
      msg = '{8'h80, 8'h41};
      queue_message(msg);
      msg = '{8'hFF};
      queue_message(msg);
      msg = '{8'hC1, 8'hBF};
      queue_message(msg);
      msg = '{8'hED, 8'hA0, 8'h80};
      queue_message(msg);
      msg = '{8'hF4, 8'h90, 8'h80, 8'h80};
      queue_message(msg);
      // sequence cut off by the end of the message
      msg = '{8'hE0};
      queue_message(msg);
      msg = '{8'hC2, 8'h41};
      queue_message(msg);
      directed_bytes = byte_queue.size();

      while (byte_queue.size() < directed_bytes + RandomBytes) begin
         build_random_message(msg);
         queue_message(msg);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (byte_queue.size() != 0 || req_chan.valid)
         @(posedge clock);
      while (expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);

      if (mismatches == 0 && expected_verdicts.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
